// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SCO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, but also active while reset is held.
`define SCO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sco_pkg.sv
// Shared widths, sizes, request codes and register indexes of the sparse column unit.
// No dependencies.
package sco_pkg;

  localparam int MAX_ROWS    = 1024;
  localparam int MAX_COLS    = 256;
  localparam int MAX_ENTRIES = 4096;

  localparam int TYPE_W  = 3;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 9;
  localparam int SLOT_W  = 13;
  localparam int EADDR_W = 12;
  localparam int DATA_W  = 32;
  localparam int VAL_W   = 48;
  localparam int NR_W    = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_SET_START   = 3'd0,
    REQ_WRITE_ENTRY = 3'd1,
    REQ_WRITE_VEC   = 3'd2,
    REQ_READ_VEC    = 3'd3,
    REQ_DOT         = 3'd4,
    REQ_AXPY        = 3'd5,
    REQ_LOOKUP      = 3'd6
  } req_type_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

endpackage

// File: rtl/core/sco_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on sco_pkg for field widths.
interface sco_req_if;
  logic                             valid;
  logic                             ready;
  logic [sco_pkg::TYPE_W-1:0]       req_type;
  logic [sco_pkg::COL_W-1:0]        column;
  logic [sco_pkg::ROW_W-1:0]        row;
  logic [sco_pkg::SLOT_W-1:0]       entry_slot;
  logic signed [sco_pkg::DATA_W-1:0] data_value;
  modport source (output valid, req_type, column, row, entry_slot, data_value, input ready);
  modport sink   (input valid, req_type, column, row, entry_slot, data_value, output ready);
endinterface

interface sco_res_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic signed [sco_pkg::VAL_W-1:0] value_out;
  logic                             found;
  logic                             saturated;
  modport source (output valid, status, value_out, found, saturated, input ready);
  modport sink   (input valid, status, value_out, found, saturated, output ready);
endinterface

// File: rtl/core/sparse_column_matrix_ops_unit.sv
// Sparse column matrix unit: CSC matrix storage, dense vector, dot/axpy/lookup sequencer.
// Depends on sco_pkg, sco_if.sv and assert_macros.svh.
//
// Loads pass from the transfer through S_POST to the output register; vector reads add S_VRD.
// Dot and axpy walk each stored entry of the column through S_E_RD, S_E_VEC, S_E_MUL and
// S_E_ACC; an entry with a stale row index is skipped after S_E_VEC. The entry memory,
// the vector memory and the one shared 32x32 multiplier are used in turn. Lookup runs
// each binary-search step through S_L_RD and S_L_CMP. After reset the vector is cleared
// in a pass over all 1024 rows during which no request is taken; configuration writes are
// taken at any time. A finished result sits in an output register and only one request
// is in flight.
`include "assert_macros.svh"

module sparse_column_matrix_ops_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  sco_req_if.sink                          in_ch,
  sco_res_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [sco_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sco_pkg::CFG_W-1:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CS_HI, S_BOUNDS, S_E_RD, S_E_VEC, S_E_MUL, S_E_ACC,
    S_L_RD, S_L_CMP, S_L_CHK, S_VRD, S_POST
  } state_t;

  localparam int CS_DEPTH = sco_pkg::MAX_COLS + 1;

  // storage
  logic [sco_pkg::SLOT_W-1:0]        cs_mem   [CS_DEPTH];
  logic [CS_DEPTH-1:0]               cs_valid_r;
  logic [sco_pkg::ROW_W-1:0]         erow_mem [sco_pkg::MAX_ENTRIES];
  logic signed [sco_pkg::DATA_W-1:0] eval_mem [sco_pkg::MAX_ENTRIES];
  logic signed [sco_pkg::DATA_W-1:0] vec_mem  [sco_pkg::MAX_ROWS];

  logic [sco_pkg::SLOT_W-1:0]        cs_q;
  logic                              cs_vq;
  logic [sco_pkg::ROW_W-1:0]         er_q;
  logic signed [sco_pkg::DATA_W-1:0] ev_q;
  logic signed [sco_pkg::DATA_W-1:0] vec_q;

  // memory ports
  logic                              cs_we, ent_we, vec_we;
  logic [sco_pkg::COL_W-1:0]         cs_waddr, cs_raddr;
  logic [sco_pkg::SLOT_W-1:0]        cs_wdata;
  logic [sco_pkg::EADDR_W-1:0]       ent_waddr, ent_raddr;
  logic [sco_pkg::ROW_W-1:0]         ent_wrow;
  logic signed [sco_pkg::DATA_W-1:0] ent_wval;
  logic [sco_pkg::ROW_W-1:0]         vec_waddr, vec_raddr;
  logic signed [sco_pkg::DATA_W-1:0] vec_wdata;

  // control and datapath registers
  state_t                            state_r, state_nxt;
  logic [sco_pkg::CFG_W-1:0]         rows_used_r, cols_used_r;
  logic [sco_pkg::ROW_W-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic [sco_pkg::TYPE_W-1:0]        type_r, type_nxt;
  logic [sco_pkg::COL_W-1:0]         col_r, col_nxt;
  logic [sco_pkg::ROW_W-1:0]         row_r, row_nxt;
  logic signed [sco_pkg::DATA_W-1:0] data_r, data_nxt;
  logic [sco_pkg::SLOT_W-1:0]        lo_r, lo_nxt, hi_r, hi_nxt, end_r, end_nxt;
  logic [sco_pkg::SLOT_W-1:0]        p_r, p_nxt, mid_r, mid_nxt;
  logic [sco_pkg::ROW_W-1:0]         er_r, er_nxt;
  logic signed [sco_pkg::DATA_W-1:0] ev_r, ev_nxt, vh_r, vh_nxt;
  logic signed [2*sco_pkg::DATA_W-1:0] prod_r, prod_nxt;
  logic signed [sco_pkg::VAL_W-1:0]  acc_r, acc_nxt;
  logic                              sat_r, sat_nxt;
  logic                              res_status_r, res_status_nxt;
  logic signed [sco_pkg::VAL_W-1:0]  res_val_r, res_val_nxt;
  logic                              res_found_r, res_found_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_status_r, out_status_nxt;
  logic signed [sco_pkg::VAL_W-1:0]  out_val_r, out_val_nxt;
  logic                              out_found_r, out_found_nxt;
  logic                              out_sat_r, out_sat_nxt;

  logic [sco_pkg::NR_W-1:0]          nr;
  logic [sco_pkg::COL_W-1:0]         nc;
  logic                              in_xfer;
  logic [sco_pkg::SLOT_W-1:0]        cs_rd, span, mid_c;
  logic signed [sco_pkg::VAL_W-1:0]  term;
  logic signed [sco_pkg::VAL_W:0]    dsum, ysum;
  logic                              y_ovf;

  assign nr = (rows_used_r > sco_pkg::CFG_W'(sco_pkg::MAX_ROWS)) ?
              sco_pkg::NR_W'(sco_pkg::MAX_ROWS) : rows_used_r;
  assign nc = (cols_used_r > sco_pkg::CFG_W'(sco_pkg::MAX_COLS)) ?
              sco_pkg::COL_W'(sco_pkg::MAX_COLS) : cols_used_r[sco_pkg::COL_W-1:0];

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.value_out = out_val_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.saturated = out_sat_r;

  assign cs_rd = cs_vq ? cs_q : '0;
  assign span  = hi_r - lo_r;
  assign mid_c = lo_r + (span >> 1);
  // floor shift of the Q32.32 product to a 48-bit Q32.16 term
  assign term  = sco_pkg::VAL_W'(prod_r >>> 16);
  assign dsum  = {acc_r[sco_pkg::VAL_W-1], acc_r} + {term[sco_pkg::VAL_W-1], term};
  assign ysum  = (sco_pkg::VAL_W+1)'(vh_r) + {term[sco_pkg::VAL_W-1], term};
  assign y_ovf = !((&ysum[sco_pkg::VAL_W:sco_pkg::DATA_W-1]) ||
                   !(|ysum[sco_pkg::VAL_W:sco_pkg::DATA_W-1]));

  always_comb begin
    state_nxt = state_r;
    clr_cnt_nxt = clr_cnt_r;
    type_nxt = type_r; col_nxt = col_r; row_nxt = row_r; data_nxt = data_r;
    lo_nxt = lo_r; hi_nxt = hi_r; end_nxt = end_r; p_nxt = p_r; mid_nxt = mid_r;
    er_nxt = er_r; ev_nxt = ev_r; vh_nxt = vh_r; prod_nxt = prod_r;
    acc_nxt = acc_r; sat_nxt = sat_r;
    res_status_nxt = res_status_r; res_val_nxt = res_val_r; res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r; out_status_nxt = out_status_r; out_val_nxt = out_val_r;
    out_found_nxt = out_found_r; out_sat_nxt = out_sat_r;
    cs_we = 1'b0; cs_waddr = in_ch.column; cs_wdata = in_ch.entry_slot; cs_raddr = col_r;
    ent_we = 1'b0; ent_waddr = in_ch.entry_slot[sco_pkg::EADDR_W-1:0];
    ent_wrow = in_ch.row; ent_wval = in_ch.data_value; ent_raddr = p_r[sco_pkg::EADDR_W-1:0];
    vec_we = 1'b0; vec_waddr = in_ch.row; vec_wdata = in_ch.data_value; vec_raddr = in_ch.row;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        vec_we = 1'b1;
        vec_waddr = clr_cnt_r;
        vec_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          type_nxt = in_ch.req_type; col_nxt = in_ch.column;
          row_nxt = in_ch.row; data_nxt = in_ch.data_value;
          res_status_nxt = sco_pkg::STATUS_BAD;
          res_val_nxt = '0; res_found_nxt = 1'b0;
          acc_nxt = '0; sat_nxt = 1'b0;
          state_nxt = S_POST;
          cs_raddr = in_ch.column;
          case (in_ch.req_type)
            sco_pkg::REQ_SET_START: begin
              if (in_ch.column <= nc &&
                  in_ch.entry_slot <= sco_pkg::SLOT_W'(sco_pkg::MAX_ENTRIES)) begin
                cs_we = 1'b1;
                res_status_nxt = sco_pkg::STATUS_OK;
              end
            end
            sco_pkg::REQ_WRITE_ENTRY: begin
              if (!in_ch.entry_slot[sco_pkg::SLOT_W-1] &&
                  sco_pkg::NR_W'(in_ch.row) < nr) begin
                ent_we = 1'b1;
                res_status_nxt = sco_pkg::STATUS_OK;
              end
            end
            sco_pkg::REQ_WRITE_VEC: begin
              if (sco_pkg::NR_W'(in_ch.row) < nr) begin
                vec_we = 1'b1;
                res_status_nxt = sco_pkg::STATUS_OK;
              end
            end
            sco_pkg::REQ_READ_VEC: begin
              if (sco_pkg::NR_W'(in_ch.row) < nr) state_nxt = S_VRD;
            end
            sco_pkg::REQ_DOT, sco_pkg::REQ_AXPY: begin
              if (in_ch.column < nc) state_nxt = S_CS_HI;
            end
            sco_pkg::REQ_LOOKUP: begin
              if (in_ch.column < nc && sco_pkg::NR_W'(in_ch.row) < nr) state_nxt = S_CS_HI;
            end
            default: ;
          endcase
        end
      end
      S_CS_HI: begin
        lo_nxt = cs_rd;
        cs_raddr = col_r + 1'b1;
        state_nxt = S_BOUNDS;
      end
      S_BOUNDS: begin
        // reversed pointers give an empty column
        hi_nxt = (cs_rd < lo_r) ? lo_r : cs_rd;
        end_nxt = (cs_rd < lo_r) ? lo_r : cs_rd;
        p_nxt = lo_r;
        res_status_nxt = sco_pkg::STATUS_OK;
        state_nxt = (type_r == sco_pkg::REQ_LOOKUP) ? S_L_RD : S_E_RD;
      end
      S_E_RD: begin
        if (p_r < end_r) begin
          state_nxt = S_E_VEC;
        end else begin
          if (type_r == sco_pkg::REQ_DOT) res_val_nxt = acc_r;
          state_nxt = S_POST;
        end
      end
      S_E_VEC: begin
        er_nxt = er_q;
        ev_nxt = ev_q;
        vec_raddr = er_q;
        if (sco_pkg::NR_W'(er_q) < nr) begin
          state_nxt = S_E_MUL;
        end else begin
          // stale row: skip the entry
          p_nxt = p_r + 1'b1;
          state_nxt = S_E_RD;
        end
      end
      S_E_MUL: begin
        vh_nxt = vec_q;
        prod_nxt = ev_r * ((type_r == sco_pkg::REQ_AXPY) ? data_r : vec_q);
        state_nxt = S_E_ACC;
      end
      S_E_ACC: begin
        if (type_r == sco_pkg::REQ_AXPY) begin
          vec_we = 1'b1;
          vec_waddr = er_r;
          if (y_ovf) begin
            sat_nxt = 1'b1;
            vec_wdata = ysum[sco_pkg::VAL_W] ? {1'b1, {(sco_pkg::DATA_W-1){1'b0}}}
                                             : {1'b0, {(sco_pkg::DATA_W-1){1'b1}}};
          end else begin
            vec_wdata = ysum[sco_pkg::DATA_W-1:0];
          end
        end else if (dsum[sco_pkg::VAL_W] != dsum[sco_pkg::VAL_W-1]) begin
          sat_nxt = 1'b1;
          acc_nxt = dsum[sco_pkg::VAL_W] ? {1'b1, {(sco_pkg::VAL_W-1){1'b0}}}
                                         : {1'b0, {(sco_pkg::VAL_W-1){1'b1}}};
        end else begin
          acc_nxt = dsum[sco_pkg::VAL_W-1:0];
        end
        p_nxt = p_r + 1'b1;
        state_nxt = S_E_RD;
      end
      S_L_RD: begin
        if (lo_r < hi_r) begin
          mid_nxt = mid_c;
          ent_raddr = mid_c[sco_pkg::EADDR_W-1:0];
          state_nxt = S_L_CMP;
        end else if (lo_r < end_r) begin
          ent_raddr = lo_r[sco_pkg::EADDR_W-1:0];
          state_nxt = S_L_CHK;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_L_CMP: begin
        if (er_q < row_r) lo_nxt = mid_r + 1'b1;
        else hi_nxt = mid_r;
        state_nxt = S_L_RD;
      end
      S_L_CHK: begin
        if (er_q == row_r) begin
          res_val_nxt = sco_pkg::VAL_W'(ev_q);
          res_found_nxt = 1'b1;
        end
        state_nxt = S_POST;
      end
      S_VRD: begin
        res_val_nxt = sco_pkg::VAL_W'(vec_q);
        res_status_nxt = sco_pkg::STATUS_OK;
        state_nxt = S_POST;
      end
      S_POST: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_val_nxt = res_val_r;
          out_found_nxt = res_found_r;
          out_sat_nxt = sat_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_cnt_r <= '0;
      out_valid_r <= 1'b0;
      rows_used_r <= sco_pkg::CFG_W'(sco_pkg::MAX_ROWS);
      cols_used_r <= '0;
      cs_valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == sco_pkg::CFG_ROWS_USED) rows_used_r <= cfg_wdata;
      if (cfg_we && cfg_index == sco_pkg::CFG_COLS_USED)
        cols_used_r <= sco_pkg::CFG_W'(cfg_wdata[sco_pkg::COL_W-1:0]);
      if (cs_we) cs_valid_r[cs_waddr] <= 1'b1;
    end
    type_r <= type_nxt; col_r <= col_nxt; row_r <= row_nxt; data_r <= data_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; end_r <= end_nxt; p_r <= p_nxt; mid_r <= mid_nxt;
    er_r <= er_nxt; ev_r <= ev_nxt; vh_r <= vh_nxt; prod_r <= prod_nxt;
    acc_r <= acc_nxt; sat_r <= sat_nxt;
    res_status_r <= res_status_nxt; res_val_r <= res_val_nxt; res_found_r <= res_found_nxt;
    out_status_r <= out_status_nxt; out_val_r <= out_val_nxt;
    out_found_r <= out_found_nxt; out_sat_r <= out_sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (cs_we) cs_mem[cs_waddr] <= cs_wdata;
    cs_q  <= cs_mem[cs_raddr];
    cs_vq <= cs_valid_r[cs_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      erow_mem[ent_waddr] <= ent_wrow;
      eval_mem[ent_waddr] <= ent_wval;
    end
    er_q <= erow_mem[ent_raddr];
    ev_q <= eval_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) vec_mem[vec_waddr] <= vec_wdata;
    vec_q <= vec_mem[vec_raddr];
  end

  `SCO_ASSERT(a_no_req_in_clear, (state_r == S_CLEAR) |-> !in_ch.ready, "request taken during clear")
  `SCO_ASSERT(a_acc_loops, (state_r == S_E_ACC) |=> (state_r == S_E_RD), "entry walk broke")
  `SCO_ASSERT(a_walk_bound, (state_r == S_E_RD) |-> (p_r <= end_r), "entry pointer past column end")
  `SCO_ASSERT(a_found_ok, (out_ch.valid && out_ch.found) |-> (out_ch.status == sco_pkg::STATUS_OK), "found with bad status")

endmodule

// File: tb/sparse_column_matrix_ops_unit_tb.sv
// Testbench for sparse_column_matrix_ops_unit: a directed table, then random CSC build/op phases.
// Depends on sco_pkg and the channel interfaces in sco_if.sv; predicts every result in-bench.
module sparse_column_matrix_ops_unit_tb;

  localparam logic [sco_pkg::TYPE_W-1:0] REQ_UNKNOWN = 3'd7;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;
  localparam longint ELEM_MAX = 64'sd2147483647;
  localparam longint ELEM_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [sco_pkg::TYPE_W-1:0] rtype;
    logic [sco_pkg::COL_W-1:0]  col;
    logic [sco_pkg::ROW_W-1:0]  row;
    logic [sco_pkg::SLOT_W-1:0] slot;
    logic [sco_pkg::DATA_W-1:0] data;
  } req_t;

  typedef struct packed {
    logic                      st;
    logic [sco_pkg::VAL_W-1:0] val;
    logic                      fnd;
    logic                      sat;
  } res_t;

  typedef struct packed {
    logic is_cfg;
    req_t q;
    logic has_exp;
    res_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [sco_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sco_pkg::CFG_W-1:0] cfg_wdata;

  sco_req_if in_ch ();
  sco_res_if out_ch ();

  sparse_column_matrix_ops_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the block's state.
  int unsigned rows_used_sh, cols_used_sh;
  int unsigned col_start_sh[sco_pkg::MAX_COLS+1];
  int unsigned ent_row_sh[sco_pkg::MAX_ENTRIES];
  logic signed [sco_pkg::DATA_W-1:0] ent_val_sh[sco_pkg::MAX_ENTRIES];
  bit ent_written[sco_pkg::MAX_ENTRIES];
  logic signed [sco_pkg::DATA_W-1:0] vec_sh[sco_pkg::MAX_ROWS];

  res_t pending_results[$];
  int mismatch_count = 0;
  bit quiet = 0;
  bit long_hold = 0;

  function automatic int unsigned eff_rows();
    return rows_used_sh > sco_pkg::MAX_ROWS ? sco_pkg::MAX_ROWS : rows_used_sh;
  endfunction

  function automatic int unsigned eff_cols();
    return cols_used_sh > sco_pkg::MAX_COLS ? sco_pkg::MAX_COLS : cols_used_sh;
  endfunction

  function automatic void col_range(int unsigned c, output int unsigned b, output int unsigned e);
    b = col_start_sh[c];
    e = col_start_sh[c+1];
    if (b > sco_pkg::MAX_ENTRIES) b = sco_pkg::MAX_ENTRIES;
    if (e > sco_pkg::MAX_ENTRIES) e = sco_pkg::MAX_ENTRIES;
    if (e < b) e = b;
  endfunction

  // Q48.16 product (16 fraction bits), floor-shifted from Q32.32.
  function automatic longint fix_mul(logic signed [sco_pkg::DATA_W-1:0] a,
                                     logic signed [sco_pkg::DATA_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  // True for a request that walks no column, or when a column walk touches only written entry slots.
  function automatic bit walk_safe(req_t q);
    int unsigned b, e;
    if (!(q.rtype inside {sco_pkg::REQ_DOT, sco_pkg::REQ_AXPY, sco_pkg::REQ_LOOKUP})) return 1;
    if (q.col >= eff_cols()) return 1;
    col_range(q.col, b, e);
    for (int unsigned p = b; p < e; p++)
      if (!ent_written[p]) return 0;
    return 1;
  endfunction

  function automatic res_t predict_request(req_t q);
    int unsigned nr, nc, c, r, s, b, e, lo, hi, mid, rr;
    longint acc, y;
    res_t o;
    nr = eff_rows();
    nc = eff_cols();
    c = q.col;
    r = q.row;
    s = q.slot;
    acc = 0;
    o = '0;
    o.st = sco_pkg::STATUS_BAD;
    case (q.rtype)
      sco_pkg::REQ_SET_START: if (c <= nc && s <= sco_pkg::MAX_ENTRIES) begin
        col_start_sh[c] = s;
        o.st = sco_pkg::STATUS_OK;
      end
      sco_pkg::REQ_WRITE_ENTRY: if (s < sco_pkg::MAX_ENTRIES && r < nr) begin
        ent_row_sh[s] = r;
        ent_val_sh[s] = q.data;
        ent_written[s] = 1;
        o.st = sco_pkg::STATUS_OK;
      end
      sco_pkg::REQ_WRITE_VEC: if (r < nr) begin
        vec_sh[r] = q.data;
        o.st = sco_pkg::STATUS_OK;
      end
      sco_pkg::REQ_READ_VEC: if (r < nr) begin
        acc = longint'(vec_sh[r]);
        o.st = sco_pkg::STATUS_OK;
      end
      sco_pkg::REQ_DOT: if (c < nc) begin
        col_range(c, b, e);
        for (int unsigned p = b; p < e; p++) begin
          rr = ent_row_sh[p];
          if (rr >= nr) continue;
          acc = acc + fix_mul(ent_val_sh[p], vec_sh[rr]);
          if (acc > SUM_MAX) begin acc = SUM_MAX; o.sat = 1; end
          else if (acc < SUM_MIN) begin acc = SUM_MIN; o.sat = 1; end
        end
        o.st = sco_pkg::STATUS_OK;
      end
      sco_pkg::REQ_AXPY: if (c < nc) begin
        col_range(c, b, e);
        for (int unsigned p = b; p < e; p++) begin
          rr = ent_row_sh[p];
          if (rr >= nr) continue;
          y = longint'(vec_sh[rr]) + fix_mul(q.data, ent_val_sh[p]);
          if (y > ELEM_MAX) begin y = ELEM_MAX; o.sat = 1; end
          else if (y < ELEM_MIN) begin y = ELEM_MIN; o.sat = 1; end
          vec_sh[rr] = y[31:0];
        end
        o.st = sco_pkg::STATUS_OK;
      end
      sco_pkg::REQ_LOOKUP: if (c < nc && r < nr) begin
        col_range(c, b, e);
        lo = b;
        hi = e;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (ent_row_sh[mid] < r) lo = mid + 1;
          else hi = mid;
        end
        if (lo < e && ent_row_sh[lo] == r) begin
          acc = longint'(ent_val_sh[lo]);
          o.fnd = 1;
        end
        o.st = sco_pkg::STATUS_OK;
      end
      default: ;
    endcase
    o.val = acc[sco_pkg::VAL_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.st) report_mismatch("status", out_ch.status, want.st);
        if (out_ch.value_out !== want.val) report_mismatch("value_out", out_ch.value_out, want.val);
        if (out_ch.found !== want.fnd) report_mismatch("found", out_ch.found, want.fnd);
        if (out_ch.saturated !== want.sat)
          report_mismatch("saturated", out_ch.saturated, want.sat);
      end
    end
  end

  // Result receiver: random stall bursts, one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offer one request and hold it until the transfer; typed expectation overrides prediction.
  task automatic send_req(req_t q, bit has_exp = 0, res_t typed = '0);
    res_t pr;
    if (!walk_safe(q)) q.rtype = sco_pkg::REQ_READ_VEC;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= q.rtype;
    in_ch.column <= q.col;
    in_ch.row <= q.row;
    in_ch.entry_slot <= q.slot;
    in_ch.data_value <= q.data;
    do @(posedge clk); while (!in_ch.ready);
    pr = predict_request(q);
    pending_results.insert(pending_results.size(), has_exp ? typed : pr);
  endtask

  task automatic cfg_write(logic [sco_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[sco_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sco_pkg::CFG_ROWS_USED) rows_used_sh = v & 32'h7FF;
    else cols_used_sh = v & 32'h1FF;
  endtask

  function automatic req_t mk(logic [sco_pkg::TYPE_W-1:0] t, int unsigned c, int unsigned r,
                              int unsigned s, logic [sco_pkg::DATA_W-1:0] d);
    req_t q;
    q.rtype = t;
    q.col = c[sco_pkg::COL_W-1:0];
    q.row = r[sco_pkg::ROW_W-1:0];
    q.slot = s[sco_pkg::SLOT_W-1:0];
    q.data = d;
    return q;
  endfunction

  function automatic dir_row_t dr(logic [sco_pkg::TYPE_W-1:0] t, int unsigned c, int unsigned r,
                                  int unsigned s, logic [sco_pkg::DATA_W-1:0] d);
    dir_row_t x;
    x = '0;
    x.q = mk(t, c, r, s, d);
    return x;
  endfunction

  function automatic dir_row_t dx(logic [sco_pkg::TYPE_W-1:0] t, int unsigned c, int unsigned r,
                                  int unsigned s, logic [sco_pkg::DATA_W-1:0] d,
                                  logic st, logic [sco_pkg::VAL_W-1:0] v, logic f);
    dir_row_t x;
    x = dr(t, c, r, s, d);
    x.has_exp = 1;
    x.exp.st = st;
    x.exp.val = v;
    x.exp.fnd = f;
    return x;
  endfunction

  function automatic dir_row_t dc(logic [sco_pkg::CFG_IDX_W-1:0] idx, int unsigned v);
    dir_row_t x;
    x = '0;
    x.is_cfg = 1;
    x.q.col = sco_pkg::COL_W'(idx);
    x.q.slot = v[sco_pkg::SLOT_W-1:0];
    return x;
  endfunction

  function automatic logic [sco_pkg::DATA_W-1:0] rand_data();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return sco_pkg::DATA_W'(int'($urandom_range(0, 524288)) - 262144);
  endfunction

  task automatic run_phase(int unsigned rows_v, int unsigned cols_v, bit hold_mid);
    int unsigned nr, nc, nbuild, first_col, p, n, r, rsel, c, k;
    int unsigned built_rows[$];
    req_t q;
    cfg_write(sco_pkg::CFG_ROWS_USED, rows_v);
    cfg_write(sco_pkg::CFG_COLS_USED, cols_v);
    nr = eff_rows();
    nc = eff_cols();
    nbuild = 0;
    first_col = 0;
    if (nc > 0) begin
      nbuild = $urandom_range(1, nc < 6 ? nc : 6);
      first_col = $urandom_range(0, nc - nbuild);
      p = $urandom_range(0, 3900);
      send_req(mk(sco_pkg::REQ_SET_START, first_col, 0, p, 0));
      for (int i = 0; i < nbuild; i++) begin
        n = $urandom_range(0, 10);
        r = $urandom_range(0, 3);
        for (int j = 0; j < n && nr > 0 && r < nr; j++) begin
          send_req(mk(sco_pkg::REQ_WRITE_ENTRY, 0, r, p, rand_data()));
          built_rows.insert(built_rows.size(), r);
          p++;
          r = r + $urandom_range(0, 50);
        end
        send_req(mk(sco_pkg::REQ_SET_START, first_col + i + 1, 0, p, 0));
      end
    end
    for (int i = 0; i < 7; i++)
      send_req(mk(sco_pkg::REQ_WRITE_VEC, 0, nr > 0 ? $urandom_range(0, nr - 1) : 0, 0,
                  rand_data()));
    for (int i = 0; i < 50; i++) begin
      if (i == 25) begin
        // Shrink or grow the row range mid-phase so stored rows can go stale.
        cfg_write(sco_pkg::CFG_ROWS_USED, $urandom_range(0, 1100));
        nr = eff_rows();
        if (hold_mid) long_hold = 1;
      end
      c = nbuild > 0 ? first_col + $urandom_range(0, nbuild - 1) : $urandom_range(0, 511);
      rsel = $urandom_range(0, 9);
      k = nr > 0 ? $urandom_range(0, nr - 1) : $urandom_range(0, 1023);
      case (rsel)
        0, 1, 2: q = mk(sco_pkg::REQ_DOT, c, 0, 0, $urandom());
        3, 4: q = mk(sco_pkg::REQ_AXPY, c, 0, 0, rand_data());
        5, 6: begin
          if (built_rows.size() > 0 && $urandom_range(0, 2) != 0)
            k = built_rows[$urandom_range(0, built_rows.size() - 1)];
          q = mk(sco_pkg::REQ_LOOKUP, c, k, 0, $urandom());
        end
        7: q = mk(sco_pkg::REQ_READ_VEC, 0, k, 0, $urandom());
        8: q = mk(sco_pkg::REQ_WRITE_VEC, 0, k, 0, rand_data());
        default: q = mk(sco_pkg::TYPE_W'($urandom_range(0, 7)), $urandom_range(0, 511),
                        $urandom_range(0, 1023), $urandom_range(0, 8191), $urandom());
      endcase
      send_req(q);
    end
  endtask

  dir_row_t dir_tab[$];

  function automatic void add_row(dir_row_t x);
    dir_tab.insert(dir_tab.size(), x);
  endfunction

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= '0;
    in_ch.column <= '0;
    in_ch.row <= '0;
    in_ch.entry_slot <= '0;
    in_ch.data_value <= '0;
    rows_used_sh = 1024;
    cols_used_sh = 0;
    foreach (col_start_sh[i]) col_start_sh[i] = 0;
    foreach (vec_sh[i]) vec_sh[i] = 0;
    foreach (ent_written[i]) begin
      ent_written[i] = 0;
      ent_row_sh[i] = 0;
      ent_val_sh[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset state, range rejects, extremes, reversed pointers, dot saturation.
    add_row(dx(sco_pkg::REQ_READ_VEC, 0, 1023, 0, 0, sco_pkg::STATUS_OK, 0, 0));
    add_row(dx(sco_pkg::REQ_DOT, 0, 0, 0, 0, sco_pkg::STATUS_BAD, 0, 0));
    add_row(dx(sco_pkg::REQ_SET_START, 0, 0, 0, 0, sco_pkg::STATUS_OK, 0, 0));
    add_row(dx(sco_pkg::REQ_SET_START, 1, 0, 0, 0, sco_pkg::STATUS_BAD, 0, 0));
    add_row(dx(sco_pkg::REQ_SET_START, 0, 0, 4097, 0, sco_pkg::STATUS_BAD, 0, 0));
    add_row(dx(sco_pkg::REQ_WRITE_ENTRY, 0, 0, 4096, 32'h1, sco_pkg::STATUS_BAD, 0, 0));
    add_row(dx(sco_pkg::REQ_WRITE_ENTRY, 0, 1023, 4095, 32'h7FFFFFFF,
               sco_pkg::STATUS_OK, 0, 0));
    add_row(dx(sco_pkg::REQ_WRITE_VEC, 0, 1023, 0, 32'h80000000, sco_pkg::STATUS_OK, 0, 0));
    add_row(dx(sco_pkg::REQ_READ_VEC, 0, 1023, 0, 0, sco_pkg::STATUS_OK, 48'hFFFF80000000, 0));
    add_row(dx(REQ_UNKNOWN, 511, 1023, 8191, 32'hFFFFFFFF, sco_pkg::STATUS_BAD, 0, 0));
    add_row(dx(sco_pkg::REQ_LOOKUP, 0, 0, 0, 0, sco_pkg::STATUS_BAD, 0, 0));
    add_row(dx(sco_pkg::REQ_AXPY, 0, 0, 0, 32'h10000, sco_pkg::STATUS_BAD, 0, 0));
    add_row(dc(sco_pkg::CFG_COLS_USED, 256));
    add_row(dx(sco_pkg::REQ_SET_START, 256, 0, 4096, 0, sco_pkg::STATUS_OK, 0, 0));
    add_row(dr(sco_pkg::REQ_SET_START, 0, 0, 4095, 0));
    add_row(dr(sco_pkg::REQ_SET_START, 1, 0, 4096, 0));
    add_row(dr(sco_pkg::REQ_DOT, 0, 0, 0, 0));
    add_row(dr(sco_pkg::REQ_AXPY, 0, 0, 0, 32'h80000000));
    add_row(dx(sco_pkg::REQ_LOOKUP, 0, 1023, 0, 0, sco_pkg::STATUS_OK, 48'h00007FFFFFFF, 1));
    add_row(dx(sco_pkg::REQ_LOOKUP, 0, 5, 0, 0, sco_pkg::STATUS_OK, 0, 0));
    add_row(dr(sco_pkg::REQ_SET_START, 1, 0, 0, 0));
    add_row(dx(sco_pkg::REQ_DOT, 0, 0, 0, 0, sco_pkg::STATUS_OK, 0, 0));
    add_row(dr(sco_pkg::REQ_WRITE_VEC, 0, 0, 0, 32'h80000000));
    for (int s = 1; s <= 3; s++) add_row(dr(sco_pkg::REQ_WRITE_ENTRY, 0, 0, s, 32'h80000000));
    add_row(dr(sco_pkg::REQ_SET_START, 2, 0, 1, 0));
    add_row(dr(sco_pkg::REQ_SET_START, 3, 0, 4, 0));
    add_row(dr(sco_pkg::REQ_DOT, 2, 0, 0, 0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg)
        cfg_write(dir_tab[i].q.col[sco_pkg::CFG_IDX_W-1:0], dir_tab[i].q.slot);
      else send_req(dir_tab[i].q, dir_tab[i].has_exp, dir_tab[i].exp);
    end

    run_phase(1024, 256, 0);
    run_phase(1, 1, 1);
    run_phase(2047, 511, 0);
    run_phase(0, 0, 0);
    run_phase($urandom_range(1, 1024), $urandom_range(1, 20), 0);
    run_phase($urandom_range(1, 1024), $urandom_range(1, 20), 0);
    quiet = 1;
    run_phase($urandom_range(1, 1024), $urandom_range(1, 20), 0);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("sparse_column_matrix_ops_unit regression: pass");
    else
      $display("sparse_column_matrix_ops_unit regression: fail");
    $finish;
  end

  // Watchdog on the whole run; a column walk may span every entry slot.
  initial begin
    #1000000000;
    $display("sparse_column_matrix_ops_unit regression: fail");
    $finish;
  end

endmodule
